/* src/ackq_pkg.sv */
// Shared types, constants and helper functions for the acknowledgement queue.
// No dependencies; every other file of the block but ackq_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ackq_pkg;

  // Ring geometry.
  localparam int QUEUE_SLOTS = 32;
  localparam int PTR_W       = $clog2(QUEUE_SLOTS);

  // Field widths.
  localparam int REQ_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int DUR_W     = 16;
  localparam int STAT_W    = 3;
  localparam int OCC_W     = 5;
  localparam int CFG_IDX_W = 4;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_APPENDED   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_SUPPRESSED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REPLACED   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DROPPED    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_POPPED     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_EMPTY      = 3'd5;
  localparam logic [STAT_W-1:0] STAT_CANCELLED  = 3'd6;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_DUPLICATE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY      = 4'd1;
  localparam logic [BYTE_W-1:0]    DUP_RESET     = 8'd2;
  localparam logic [BYTE_W-1:0]    BUSY_RESET    = 8'd3;

  // One stored acknowledgement record.
  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] goal;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] board;
    logic [DUR_W-1:0]  dur;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Memory port controls driven by the sequencer.
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    rec_t             wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } mem_ctl_t;

  // Outcome of the shared record compare unit.
  typedef struct packed {
    logic dup_hit;
    logic rep_hit;
  } cmp_res_t;

  // Next slot around the ring.
  function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    if (p == PTR_W'(QUEUE_SLOTS - 1)) begin
      q = '0;
    end else begin
      q = p + 1'b1;
    end
    return q;
  endfunction

  // Records held between head and tail, reported in the occupancy width.
  function automatic logic [OCC_W-1:0] ring_held(input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] rp);
    logic [PTR_W:0] diff;
    if (wp >= rp) begin
      diff = {1'b0, wp} - {1'b0, rp};
    end else begin
      diff = {1'b0, wp} + (PTR_W+1)'(QUEUE_SLOTS) - {1'b0, rp};
    end
    return OCC_W'(diff);
  endfunction

  // An ack code is repetitive when it equals either configured code.
  function automatic logic is_rep(input logic [BYTE_W-1:0] code,
                                  input logic [BYTE_W-1:0] dup_code,
                                  input logic [BYTE_W-1:0] busy_code);
    return (code == dup_code) || (code == busy_code);
  endfunction

endpackage

`default_nettype wire

/* src/ackq_if.sv */
// Handshake interfaces for the request, result and configuration channels.
// Depends on ackq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one item per push, pop or cancel.
interface ackq_in_if import ackq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] ack_code;
  logic [BYTE_W-1:0] goal_id;
  logic [BYTE_W-1:0] axis_mask;
  logic [BYTE_W-1:0] board_state;
  logic [DUR_W-1:0]  goal_dur;

  modport source (output valid, req_type, ack_code, goal_id, axis_mask, board_state,
                  goal_dur, input ready);
  modport sink   (input valid, req_type, ack_code, goal_id, axis_mask, board_state,
                  goal_dur, output ready);
endinterface

// Result channel: one item for every request.
interface ackq_out_if import ackq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] out_ack_code;
  logic [BYTE_W-1:0] out_goal_id;
  logic [BYTE_W-1:0] out_axis_mask;
  logic [BYTE_W-1:0] out_board_state;
  logic [DUR_W-1:0]  out_goal_dur;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, status, out_ack_code, out_goal_id, out_axis_mask,
                  out_board_state, out_goal_dur, occupancy, input ready);
  modport sink   (input valid, status, out_ack_code, out_goal_id, out_axis_mask,
                  out_board_state, out_goal_dur, occupancy, output ready);
endinterface

// Configuration write channel.
interface ackq_cfg_if import ackq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/ackq_ram.sv */
// Generic single-write, single-read memory with a registered read port.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ackq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/ackq_cmp.sv */
// Shared compare unit: checks one stored record against the pending push.
// Depends on ackq_pkg for rec_t, cmp_res_t and is_rep.
`timescale 1ns / 1ps
`default_nettype none

module ackq_cmp import ackq_pkg::*; (
  input  wire rec_t              stored,
  input  wire rec_t              pending,
  input  wire logic [BYTE_W-1:0] dup_code,
  input  wire logic [BYTE_W-1:0] busy_code,
  output      cmp_res_t          res
);

  // Equal record, board state ignored; and repetitive test on the stored code.
  always_comb begin
    res.dup_hit = (stored.code == pending.code) && (stored.goal == pending.goal) &&
                  (stored.mask == pending.mask) && (stored.dur == pending.dur);
    res.rep_hit = is_rep(stored.code, dup_code, busy_code);
  end

endmodule

`default_nettype wire

/* src/ackq_seq.sv */
// Sequencer of the queue: takes a request item, walks the ring through the
// memory read port, and registers the result item. Depends on ackq_pkg, ackq_if.
`timescale 1ns / 1ps
`default_nettype none

module ackq_seq import ackq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ackq_in_if.sink                in_if,
  ackq_out_if.source             out_if,
  input  wire logic [BYTE_W-1:0] dup_code,
  input  wire logic [BYTE_W-1:0] busy_code,
  input  wire rec_t              rd_data,
  input  wire cmp_res_t          cmp_res,
  output      rec_t              cur_rec,
  output      mem_ctl_t          mem_ctl
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_POP  = 4'b0100,
    ST_SCAN = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  rec_t              rec_r, rec_nxt;
  logic              mode_rep_r, mode_rep_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  issue_r, issue_nxt;
  logic [PTR_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_stat_r;
  rec_t              out_rec_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic              emit;
  logic [STAT_W-1:0] emit_stat;
  rec_t              emit_rec;
  logic              out_free;
  logic              empty;
  logic              full;
  logic              new_rep;
  logic              hit;

  assign out_free = !out_valid_r || out_if.ready;
  assign empty    = (rp_r == wp_r);
  assign full     = (ring_adv(wp_r) == rp_r);
  assign new_rep  = is_rep(rec_r.code, dup_code, busy_code);
  assign hit      = mode_rep_r ? cmp_res.rep_hit : cmp_res.dup_hit;
  assign cur_rec  = rec_r;

  assign in_if.ready = (state_r == ST_IDLE);

  // Sequencer: decides each request and steps the ring scan.
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    rec_nxt      = rec_r;
    mode_rep_nxt = mode_rep_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    issue_nxt    = issue_r;
    chk_idx_nxt  = chk_idx_r;
    chk_vld_nxt  = chk_vld_r;
    mem_ctl      = '0;
    emit         = 1'b0;
    emit_stat    = STAT_APPENDED;
    emit_rec     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          req_nxt       = in_if.req_type;
          rec_nxt.code  = in_if.ack_code;
          rec_nxt.goal  = in_if.goal_id;
          rec_nxt.mask  = in_if.axis_mask;
          rec_nxt.board = in_if.board_state;
          rec_nxt.dur   = in_if.goal_dur;
          state_nxt     = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (req_r)
          REQ_PUSH: begin
            if (new_rep && !empty) begin
              // Look for an equal record already queued.
              mode_rep_nxt = 1'b0;
              issue_nxt    = rp_r;
              chk_vld_nxt  = 1'b0;
              state_nxt    = ST_SCAN;
            end else if (full && !new_rep) begin
              // Look for a repetitive record to overwrite.
              mode_rep_nxt = 1'b1;
              issue_nxt    = rp_r;
              chk_vld_nxt  = 1'b0;
              state_nxt    = ST_SCAN;
            end else if (out_free) begin
              if (full) begin
                emit      = 1'b1;
                emit_stat = STAT_DROPPED;
              end else begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = wp_r;
                mem_ctl.wdata = rec_r;
                wp_nxt        = ring_adv(wp_r);
                emit          = 1'b1;
                emit_stat     = STAT_APPENDED;
              end
              state_nxt = ST_IDLE;
            end
          end
          REQ_POP: begin
            if (empty) begin
              if (out_free) begin
                emit      = 1'b1;
                emit_stat = STAT_EMPTY;
                state_nxt = ST_IDLE;
              end
            end else begin
              mem_ctl.re    = 1'b1;
              mem_ctl.raddr = rp_r;
              state_nxt     = ST_POP;
            end
          end
          default: begin
            // Cancel; the unused request code acts the same way.
            if (out_free) begin
              rp_nxt    = wp_r;
              emit      = 1'b1;
              emit_stat = STAT_CANCELLED;
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end

      ST_POP: begin
        if (out_free) begin
          rp_nxt    = ring_adv(rp_r);
          emit      = 1'b1;
          emit_stat = STAT_POPPED;
          emit_rec  = rd_data;
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (chk_vld_r && hit) begin
          // Found: suppress the duplicate or overwrite in place.
          if (out_free) begin
            if (mode_rep_r) begin
              mem_ctl.we    = 1'b1;
              mem_ctl.waddr = chk_idx_r;
              mem_ctl.wdata = rec_r;
              emit_stat     = STAT_REPLACED;
            end else begin
              emit_stat     = STAT_SUPPRESSED;
            end
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (issue_r == wp_r) begin
          // Whole ring checked without a hit.
          chk_vld_nxt = 1'b0;
          if (out_free) begin
            if (!mode_rep_r && !full) begin
              mem_ctl.we    = 1'b1;
              mem_ctl.waddr = wp_r;
              mem_ctl.wdata = rec_r;
              wp_nxt        = ring_adv(wp_r);
              emit_stat     = STAT_APPENDED;
            end else begin
              emit_stat     = STAT_DROPPED;
            end
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          // Fetch the next record; it is checked in the following cycle.
          mem_ctl.re    = 1'b1;
          mem_ctl.raddr = issue_r;
          chk_idx_nxt   = issue_r;
          chk_vld_nxt   = 1'b1;
          issue_nxt     = ring_adv(issue_r);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register; a new item may be loaded as the old one is taken.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rec_r      <= rec_nxt;
    mode_rep_r <= mode_rep_nxt;
    issue_r    <= issue_nxt;
    chk_idx_r  <= chk_idx_nxt;
    if (emit) begin
      out_stat_r <= emit_stat;
      out_rec_r  <= emit_rec;
      out_occ_r  <= ring_held(wp_nxt, rp_nxt);
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_stat_r;
  assign out_if.out_ack_code    = out_rec_r.code;
  assign out_if.out_goal_id     = out_rec_r.goal;
  assign out_if.out_axis_mask   = out_rec_r.mask;
  assign out_if.out_board_state = out_rec_r.board;
  assign out_if.out_goal_dur    = out_rec_r.dur;
  assign out_if.occupancy       = out_occ_r;

endmodule

`default_nettype wire

/* src/ack_queue_with_dedup.sv */
// Ring queue of acknowledgement records with suppression of repeated pushes.
// An item is taken in one cycle and decided in the next: cancel, append and empty
// pop finish in ST_EXEC, a pop finishes in ST_POP, and a push that scans the ring
// checks one record per cycle in ST_SCAN; an untaken result stalls it.
// Synchronous reset (rst_n low) empties the ring and loads the default codes.
// Depends on ackq_pkg, ackq_if, ackq_ram, ackq_cmp and ackq_seq.
`timescale 1ns / 1ps
`default_nettype none

module ack_queue_with_dedup import ackq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ackq_in_if.sink    in_if,
  ackq_out_if.source out_if,
  ackq_cfg_if.sink   cfg_if
);

  logic [BYTE_W-1:0] dup_code_r;
  logic [BYTE_W-1:0] busy_code_r;
  mem_ctl_t          mem_ctl;
  logic [REC_W-1:0]  rd_word;
  rec_t              rd_data;
  rec_t              cur_rec;
  cmp_res_t          cmp_res;

  // Configuration registers; writes to other indexes are ignored.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_code_r  <= DUP_RESET;
      busy_code_r <= BUSY_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_DUPLICATE: dup_code_r  <= cfg_if.data;
        REG_BUSY:      busy_code_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Record store.
  ackq_ram #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_ctl.we),
    .waddr (mem_ctl.waddr),
    .wdata (mem_ctl.wdata),
    .re    (mem_ctl.re),
    .raddr (mem_ctl.raddr),
    .rdata (rd_word)
  );

  assign rd_data = rd_word;

  // Shared record compare.
  ackq_cmp u_cmp (
    .stored    (rd_data),
    .pending   (cur_rec),
    .dup_code  (dup_code_r),
    .busy_code (busy_code_r),
    .res       (cmp_res)
  );

  // Sequencer and result register.
  ackq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .dup_code  (dup_code_r),
    .busy_code (busy_code_r),
    .rd_data   (rd_data),
    .cmp_res   (cmp_res),
    .cur_rec   (cur_rec),
    .mem_ctl   (mem_ctl)
  );

  // The memory is never written and read in the same cycle.
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.we && mem_ctl.re))
    else $error("memory written and read in the same cycle");

  // After an item is taken the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request taken while the previous one is still being decided");

  // Every memory write comes with a result item.
  a_write_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.we |=> out_if.valid)
    else $error("record stored without a result item");

  // A memory write leaves the sequencer ready for the next item.
  a_write_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.we |=> in_if.ready)
    else $error("record stored before the item was finished");

endmodule

`default_nettype wire

/* sim/ackq_checker.sv */
// Checker for the acknowledgement queue: watches the request, result and
// configuration channels, predicts every result item and compares it.
// Depends on ackq_pkg and the channel interfaces in ackq_if.
`timescale 1ns / 1ps

module ackq_checker import ackq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ackq_in_if        in_mon,
  ackq_out_if       out_mon,
  ackq_cfg_if       cfg_mon,
  output int        error_count,
  output int        pending_acks
);

  // One predicted result item.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    rec_t              rec;
    logic [OCC_W-1:0]  occ;
  } ack_result_t;

  // Private copy of the ring, its pointers and the two code registers.
  rec_t              ring_store [QUEUE_SLOTS];
  int unsigned       head_slot;
  int unsigned       tail_slot;
  logic [BYTE_W-1:0] dup_code_r;
  logic [BYTE_W-1:0] busy_code_r;

  ack_result_t expected_acks [$];
  ack_result_t oldest_ack;

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic logic code_repeats(input logic [BYTE_W-1:0] code);
    return (code == dup_code_r) || (code == busy_code_r);
  endfunction

  // Apply one request to the private ring and return the result it yields.
  function automatic ack_result_t predict_ack(input logic [REQ_W-1:0] kind,
                                              input rec_t item);
    ack_result_t res;
    int unsigned slot;
    logic        repeats;
    logic        settled;
    res = '0;
    if (kind == REQ_PUSH) begin
      repeats = code_repeats(item.code);
      settled = 1'b0;
      res.status = STAT_APPENDED;
      // A repetitive record equal to a held one, board state aside, is suppressed.
      if (repeats) begin
        for (slot = head_slot; slot != tail_slot && !settled;
             slot = (slot + 1) % QUEUE_SLOTS) begin
          if (ring_store[slot].code == item.code && ring_store[slot].goal == item.goal &&
              ring_store[slot].mask == item.mask && ring_store[slot].dur == item.dur) begin
            res.status = STAT_SUPPRESSED;
            settled = 1'b1;
          end
        end
      end
      // A full ring drops the push, unless a non-repetitive one can take the
      // place of the first repetitive record from the head.
      if (!settled && (tail_slot + 1) % QUEUE_SLOTS == head_slot) begin
        settled = 1'b1;
        res.status = STAT_DROPPED;
        if (!repeats) begin
          for (slot = head_slot; slot != tail_slot && res.status == STAT_DROPPED;
               slot = (slot + 1) % QUEUE_SLOTS) begin
            if (code_repeats(ring_store[slot].code)) begin
              ring_store[slot] = item;
              res.status = STAT_REPLACED;
            end
          end
        end
      end
      if (!settled) begin
        ring_store[tail_slot] = item;
        tail_slot = (tail_slot + 1) % QUEUE_SLOTS;
      end
    end else if (kind == REQ_POP) begin
      if (head_slot != tail_slot) begin
        res.rec = ring_store[head_slot];
        head_slot = (head_slot + 1) % QUEUE_SLOTS;
        res.status = STAT_POPPED;
      end else begin
        res.status = STAT_EMPTY;
      end
    end else begin
      // Cancel, and the unused request code that behaves the same way.
      head_slot = tail_slot;
      res.status = STAT_CANCELLED;
    end
    res.occ = OCC_W'((tail_slot + QUEUE_SLOTS - head_slot) % QUEUE_SLOTS);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head_slot = 0;
      tail_slot = 0;
      dup_code_r = DUP_RESET;
      busy_code_r = BUSY_RESET;
      expected_acks.delete();
      error_count = 0;
    end else begin
      // Compare a delivered result item with the oldest expectation.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_acks.size() == 0) begin
          flag_mismatch("result item with none expected", out_mon.status, '0);
        end else begin
          oldest_ack = expected_acks.pop_front();
          if (out_mon.status !== oldest_ack.status)
            flag_mismatch("status", out_mon.status, oldest_ack.status);
          if (out_mon.out_ack_code !== oldest_ack.rec.code)
            flag_mismatch("ack code", out_mon.out_ack_code, oldest_ack.rec.code);
          if (out_mon.out_goal_id !== oldest_ack.rec.goal)
            flag_mismatch("goal id", out_mon.out_goal_id, oldest_ack.rec.goal);
          if (out_mon.out_axis_mask !== oldest_ack.rec.mask)
            flag_mismatch("axis mask", out_mon.out_axis_mask, oldest_ack.rec.mask);
          if (out_mon.out_board_state !== oldest_ack.rec.board)
            flag_mismatch("board state", out_mon.out_board_state, oldest_ack.rec.board);
          if (out_mon.out_goal_dur !== oldest_ack.rec.dur)
            flag_mismatch("duration", out_mon.out_goal_dur, oldest_ack.rec.dur);
          if (out_mon.occupancy !== oldest_ack.occ)
            flag_mismatch("occupancy", out_mon.occupancy, oldest_ack.occ);
        end
      end
      // Track register writes; unmapped indexes change nothing.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_DUPLICATE: dup_code_r = cfg_mon.data;
          REG_BUSY:      busy_code_r = cfg_mon.data;
          default: ;
        endcase
      end
      // Every accepted request item yields exactly one result item.
      if (in_mon.valid && in_mon.ready) begin
        expected_acks.push_back(predict_ack(in_mon.req_type, '{code:  in_mon.ack_code,
                                                              goal:  in_mon.goal_id,
                                                              mask:  in_mon.axis_mask,
                                                              board: in_mon.board_state,
                                                              dur:   in_mon.goal_dur}));
      end
    end
    pending_acks <= expected_acks.size();
  end

endmodule

/* sim/tb_ack_queue_with_dedup.sv */
// Testbench top for the acknowledgement queue: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on ackq_pkg, ackq_if, ackq_checker and the block itself.
`timescale 1ns / 1ps

module tb_ack_queue_with_dedup import ackq_pkg::*; ();

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_ITEMS    = 1500;
  localparam int SEGMENTS        = 6;
  localparam int SETTLE_CYCLES   = QUEUE_SLOTS + 8;
  localparam int HOLD_OFF_CYCLES = 300;

  // Request code with no meaning of its own, and a register index with no register.
  localparam logic [REQ_W-1:0]     REQ_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd9;

  logic              clk = 1'b0;
  logic              rst_n;
  int                cycle_count = 0;
  int                mismatches;
  int                pending_acks;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_kick = 0;
  logic [BYTE_W-1:0] cur_dup;
  logic [BYTE_W-1:0] cur_busy;

  ackq_in_if  in_ch ();
  ackq_out_if out_ch ();
  ackq_cfg_if cfg_ch ();

  ack_queue_with_dedup u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  ackq_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .error_count  (mismatches),
    .pending_acks (pending_acks)
  );

  always #CLK_HALF clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls, plus a long hold-off whenever asked for.
  initial begin : receiver
    int hold_left;
    int kick_seen;
    hold_left = 0;
    kick_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_kick != kick_seen) begin
        kick_seen = hold_kick;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request item and wait until it is accepted; valid stays high.
  task automatic send_req(input logic [REQ_W-1:0] kind,
                          input logic [BYTE_W-1:0] code, goal, mask, board,
                          input logic [DUR_W-1:0] dur);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.ack_code    <= code;
    in_ch.goal_id     <= goal;
    in_ch.axis_mask   <= mask;
    in_ch.board_state <= board;
    in_ch.goal_dur    <= dur;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Either a full-range byte or one from a small pool, so that repeats occur.
  function automatic logic [BYTE_W-1:0] pick_byte(input logic wide);
    if (wide) return BYTE_W'($urandom_range(255));
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h80;
      default: return 8'hFF;
    endcase
  endfunction

  // Push a record whose code is repetitive with the given odds.
  task automatic send_push(input int rep_pct, input logic wide);
    logic [BYTE_W-1:0] code;
    logic [DUR_W-1:0]  dur;
    if ($urandom_range(99) < rep_pct) begin
      code = $urandom_range(1) ? cur_dup : cur_busy;
    end else begin
      do code = BYTE_W'($urandom_range(255)); while (code == cur_dup || code == cur_busy);
    end
    if (wide) begin
      dur = DUR_W'($urandom_range(65535));
    end else begin
      case ($urandom_range(2))
        0:       dur = 16'h0000;
        1:       dur = 16'h0001;
        default: dur = 16'hFFFF;
      endcase
    end
    send_req(REQ_PUSH, code, pick_byte(wide), pick_byte(wide), pick_byte(1'b1), dur);
  endtask

  // Drop valid, wait until every result item has come back, then let the block settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_acks != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both code registers and one unmapped index while the block is idle.
  task automatic program_codes(input logic [BYTE_W-1:0] dup, input logic [BYTE_W-1:0] busy);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_DUPLICATE;
    cfg_ch.data  <= dup;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= REG_BUSY;
    cfg_ch.data  <= busy;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= REG_UNMAPPED;
    cfg_ch.data  <= BYTE_W'($urandom_range(255));
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_dup = dup;
    cur_busy = busy;
  endtask

  // Random traffic: ring-sized push bursts that may overflow, drains, and single mixed requests.
  task automatic run_random(input int budget, input logic with_hold);
    int sent;
    int pick;
    int burst;
    int rep_pct;
    int hold_at;
    sent = 0;
    hold_at = with_hold ? budget / 2 : -1;
    while (sent < budget) begin
      // Long receiver hold-off while requests keep coming.
      if (hold_at >= 0 && sent >= hold_at) begin
        hold_kick <= hold_kick + 1;
        hold_at = -1;
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        // Push QUEUE_SLOTS-4 to QUEUE_SLOTS+6 records; some bursts have no repetitive code.
        burst = $urandom_range(QUEUE_SLOTS + 6, QUEUE_SLOTS - 4);
        case ($urandom_range(2))
          0:       rep_pct = 0;
          1:       rep_pct = 60;
          default: rep_pct = 100;
        endcase
        repeat (burst) send_push(rep_pct, $urandom_range(3) != 0);
        sent += burst;
      end else if (pick < 28) begin
        // Drain part of the ring.
        burst = $urandom_range(QUEUE_SLOTS, 1);
        repeat (burst) begin
          send_req(REQ_POP, pick_byte(1'b1), pick_byte(1'b1), pick_byte(1'b1),
                   pick_byte(1'b1), DUR_W'($urandom_range(65535)));
        end
        sent += burst;
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_push(50, $urandom_range(1) != 0);
        end else begin
          send_req((pick < 85) ? REQ_POP : (pick < 93) ? REQ_CANCEL : REQ_SPARE,
                   pick_byte(1'b1), pick_byte(1'b1), pick_byte(1'b1), pick_byte(1'b1),
                   DUR_W'($urandom_range(65535)));
        end
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int seg;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_PUSH;
    in_ch.ack_code    <= '0;
    in_ch.goal_id     <= '0;
    in_ch.axis_mask   <= '0;
    in_ch.board_state <= '0;
    in_ch.goal_dur    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_DUPLICATE;
    cfg_ch.data       <= '0;
    rst_n             <= 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 50;
    cur_dup = DUP_RESET;
    cur_busy = BUSY_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset codes.
    send_req(REQ_POP,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);  // pop of an empty ring
    send_req(REQ_PUSH,   8'h02, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_req(REQ_PUSH,   8'h02, 8'h00, 8'h00, 8'hFF, 16'h0000);  // board state ignored
    send_req(REQ_PUSH,   8'h02, 8'h00, 8'h00, 8'h00, 16'h0001);  // duration differs
    send_req(REQ_PUSH,   8'h03, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_req(REQ_PUSH,   8'h03, 8'hFF, 8'hFF, 8'h00, 16'hFFFF);
    send_req(REQ_PUSH,   8'h03, 8'hFF, 8'hFE, 8'h00, 16'hFFFF);  // mask differs
    send_req(REQ_PUSH,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_req(REQ_PUSH,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);  // never suppressed
    send_req(REQ_PUSH,   8'h00, 8'h55, 8'hAA, 8'h5A, 16'hA5A5);
    send_req(REQ_POP,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_req(REQ_POP,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_req(REQ_SPARE,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);  // acts as a cancel
    send_req(REQ_POP,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_req(REQ_PUSH,   8'h02, 8'h01, 8'h02, 8'h03, 16'h1234);
    send_req(REQ_CANCEL, 8'hAA, 8'h55, 8'hAA, 8'h55, 16'h5555);
    send_req(REQ_POP,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);

    // Random segments, each under its own codes; the idling pattern changes at segments 2 and 4.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 50;
        recv_idle_pct = 38;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      case (seg)
        0:       program_codes(DUP_RESET, BUSY_RESET);
        1:       program_codes(8'h00, 8'hFF);
        2:       program_codes(8'hFF, 8'h00);
        3:       program_codes(8'h55, 8'h55);
        default: program_codes(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
      endcase
      run_random(RANDOM_ITEMS / SEGMENTS, seg == 1 || seg == 4);
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* ack_queue_with_dedup.f */
src/ackq_pkg.sv
src/ackq_if.sv
src/ackq_ram.sv
src/ackq_cmp.sv
src/ackq_seq.sv
src/ack_queue_with_dedup.sv
sim/ackq_checker.sv
sim/tb_ack_queue_with_dedup.sv
